/* design/h3w_pkg.sv */
// ----------------------------------------------------------------------------
// h3w_pkg
// Shared constants, types and header helpers of the three-wire SLIP deframer.
// ----------------------------------------------------------------------------
package h3w_pkg;

	localparam logic [7:0] SLIP_DELIM    = 8'hC0;
	localparam logic [7:0] ESC_CODE      = 8'hDB;
	localparam logic [7:0] ESC_FOR_DELIM = 8'hDC;
	localparam logic [7:0] ESC_FOR_ESC   = 8'hDD;
	localparam logic [7:0] HDR_SUM_OK    = 8'hFF;
	localparam logic [3:0] PKT_LINK      = 4'hF;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int CNT_W = 13;
	localparam int LEN_W = 12;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DONE = 2'd1;
	localparam logic [1:0] EV_CSUM = 2'd2;
	localparam logic [1:0] EV_SLIP = 2'd3;

	localparam int LINK_NUM = 7;
	localparam logic [7:0] LINK_SECOND [LINK_NUM] =
		'{8'h7E, 8'h7D, 8'hFC, 8'h7B, 8'hFA, 8'hF9, 8'h78};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_delim;
		logic       is_esc;
		logic       is_esc_end;
		logic       is_esc_esc;
	} cls_t;

	typedef struct packed {
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [1:0]       event_res;
		logic [3:0]       packet_type;
		logic [2:0]       seq_number;
		logic [2:0]       ack_number;
		logic             reliable_flag;
		logic             crc_present;
		logic [LEN_W-1:0] payload_length;
		logic [2:0]       link_message;
	} res_t;

	function automatic logic [LEN_W-1:0] hdr_length(input logic [31:0] hdr);
		return {hdr[23:16], hdr[15:12]};
	endfunction

	function automatic res_t put_header(input res_t r, input logic [31:0] hdr);
		res_t o;
		o                = r;
		o.packet_type    = hdr[11:8];
		o.seq_number     = hdr[2:0];
		o.ack_number     = hdr[5:3];
		o.reliable_flag  = hdr[7];
		o.crc_present    = hdr[6];
		o.payload_length = hdr_length(hdr);
		return o;
	endfunction

	function automatic logic [2:0] link_code(input logic [15:0] pfx,
	                                         input logic [31:0] hdr);
		logic [2:0] code;
		code = 3'd0;
		if (hdr[11:8] == PKT_LINK && hdr_length(hdr) >= LEN_W'(2)) begin
			for (int i = 0; i < LINK_NUM; i++) begin
				if (pfx[7:0] == 8'(i + 1) && pfx[15:8] == LINK_SECOND[i])
					code = 3'(i + 1);
			end
		end
		return code;
	endfunction

endpackage

/* design/h3w_in_if.sv */
// ----------------------------------------------------------------------------
// h3w_in_if
// Raw UART byte channel.
// ----------------------------------------------------------------------------
interface h3w_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

/* design/h3w_out_if.sv */
// ----------------------------------------------------------------------------
// h3w_out_if
// Deframed result channel.
// ----------------------------------------------------------------------------
interface h3w_out_if;
	logic        valid;
	logic        ready;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [1:0]  event_res;
	logic [3:0]  packet_type;
	logic [2:0]  seq_number;
	logic [2:0]  ack_number;
	logic        reliable_flag;
	logic        crc_present;
	logic [11:0] payload_length;
	logic [2:0]  link_message;

	modport source (output valid, output data_valid, output data_byte, output event_res,
		output packet_type, output seq_number, output ack_number, output reliable_flag,
		output crc_present, output payload_length, output link_message, input ready);
	modport sink (input valid, input data_valid, input data_byte, input event_res,
		input packet_type, input seq_number, input ack_number, input reliable_flag,
		input crc_present, input payload_length, input link_message, output ready);
endinterface

/* design/hci_three_wire_slip_deframer.sv */
// ----------------------------------------------------------------------------
// hci_three_wire_slip_deframer
// Three-wire HCI SLIP deframer: raw UART bytes in, decoded payload bytes and
// frame events out.
//
//   channel   | dir | payload
//   ----------+-----+---------------------------------------------------------
//   uart      | in  | in_byte
//   deframed  | out | data_valid, data_byte, event_res, header fields,
//             |     | link_message
//
// One byte per cycle sustained while results are taken; the frame state
// machine takes a byte whenever its result register is free or being read.
// A byte passes the front register, the queue and the result register. Reset
// clears all control state at once; no clearing pass. A stalled result holds
// and the four-entry queue keeps the input side taking bytes until it fills.
// ----------------------------------------------------------------------------
module hci_three_wire_slip_deframer (
	input  logic      clk,
	input  logic      arst_n,
	h3w_in_if.sink    uart,
	h3w_out_if.source deframed
);
	import h3w_pkg::*;

	logic cls_valid, cls_ready, q_valid, q_ready, res_valid;
	cls_t cls, q_item;
	res_t res;

	h3w_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (uart.valid),
		.in_byte   (uart.in_byte),
		.in_ready  (uart.ready),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_ready (cls_ready)
	);

	h3w_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_data  (cls),
		.push_ready (cls_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_item),
		.pop_ready  (q_ready)
	);

	h3w_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.item_ready (q_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (deframed.ready)
	);

	assign deframed.valid          = res_valid;
	assign deframed.data_valid     = res.data_valid;
	assign deframed.data_byte      = res.data_byte;
	assign deframed.event_res      = res.event_res;
	assign deframed.packet_type    = res.packet_type;
	assign deframed.seq_number     = res.seq_number;
	assign deframed.ack_number     = res.ack_number;
	assign deframed.reliable_flag  = res.reliable_flag;
	assign deframed.crc_present    = res.crc_present;
	assign deframed.payload_length = res.payload_length;
	assign deframed.link_message   = res.link_message;

endmodule

/* design/h3w_front.sv */
// ----------------------------------------------------------------------------
// h3w_front
// Accept raw bytes and tag SLIP delimiter and escape codes.
// ----------------------------------------------------------------------------
module h3w_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	output logic          in_ready,
	output logic          cls_valid,
	output h3w_pkg::cls_t cls,
	input  logic          cls_ready
);
	import h3w_pkg::*;

	logic valid_s1;
	cls_t cls_s1;

	assign in_ready  = !valid_s1 || cls_ready;
	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1.in_byte    <= in_byte;
			cls_s1.is_delim   <= (in_byte == SLIP_DELIM);
			cls_s1.is_esc     <= (in_byte == ESC_CODE);
			cls_s1.is_esc_end <= (in_byte == ESC_FOR_DELIM);
			cls_s1.is_esc_esc <= (in_byte == ESC_FOR_ESC);
		end
	end

endmodule

/* design/h3w_fifo.sv */
// ----------------------------------------------------------------------------
// h3w_fifo
// Short queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module h3w_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  h3w_pkg::cls_t push_data,
	output logic          push_ready,
	output logic          pop_valid,
	output h3w_pkg::cls_t pop_data,
	input  logic          pop_ready
);
	import h3w_pkg::*;

	cls_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

/* design/h3w_back.sv */
// ----------------------------------------------------------------------------
// h3w_back
// Frame state machine: unescape, header check, payload and frame events.
// ----------------------------------------------------------------------------
module h3w_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  h3w_pkg::cls_t item,
	output logic          item_ready,
	output logic          res_valid,
	output h3w_pkg::res_t res,
	input  logic          res_ready
);
	import h3w_pkg::*;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_SKIP    = 3'd1;
	localparam logic [2:0] PH_HEADER  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRC     = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((1 << LEN_W) - 1 + 6);

	logic [2:0]       phase_q, ph_n, cur_ph;
	logic             esc_q, esc_n, esc_b;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_b, cnt_inc;
	logic [31:0]      hdr_q, hdr_n, hdr_b, hdr_acc;
	logic [15:0]      pfx_q, pfx_n, pfx_b;
	logic [LEN_W-1:0] len_acc, len_b;
	logic [7:0]       d, csum;
	logic             bad, start, framed, emit, finish, fire;
	res_t             r;
	res_t             res_q;
	logic             res_valid_q;

	assign item_ready = !res_valid_q || res_ready;
	assign fire       = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		ph_n    = phase_q;
		esc_n   = esc_q;
		cnt_n   = cnt_q;
		hdr_n   = hdr_q;
		pfx_n   = pfx_q;
		emit    = 1'b0;
		finish  = 1'b0;
		r       = '0;
		start   = (phase_q == PH_SKIP) && !item.is_delim;
		framed  = start || (phase_q inside {PH_HEADER, PH_PAYLOAD, PH_CRC});
		cur_ph  = start ? PH_HEADER : phase_q;
		esc_b   = start ? 1'b0 : esc_q;
		cnt_b   = start ? '0 : cnt_q;
		hdr_b   = start ? '0 : hdr_q;
		pfx_b   = start ? '0 : pfx_q;
		cnt_inc = cnt_b + 1'b1;
		d       = item.in_byte;
		bad     = item.is_delim;
		if (esc_b) begin
			d   = item.is_esc_end ? SLIP_DELIM : ESC_CODE;
			bad = bad || !(item.is_esc_end || item.is_esc_esc);
		end
		hdr_acc = hdr_b | ({24'd0, d} << {cnt_b[1:0], 3'b000});
		len_acc = hdr_length(hdr_acc);
		len_b   = hdr_length(hdr_b);
		csum    = hdr_acc[7:0] + hdr_acc[15:8] + hdr_acc[23:16] + hdr_acc[31:24];

		if (!framed) begin
			if (phase_q != PH_SKIP)
				ph_n = item.is_delim ? PH_SKIP : PH_HUNT;
		end else begin
			ph_n  = cur_ph;
			esc_n = esc_b;
			cnt_n = cnt_b;
			hdr_n = hdr_b;
			pfx_n = pfx_b;
			if (!esc_b && item.is_esc) begin
				esc_n = 1'b1;
			end else if (bad) begin
				ph_n        = PH_HUNT;
				esc_n       = 1'b0;
				emit        = 1'b1;
				r.event_res = EV_SLIP;
			end else begin
				esc_n = 1'b0;
				cnt_n = cnt_inc;
				case (cur_ph)
					PH_HEADER: begin
						hdr_n = hdr_acc;
						if (cnt_inc == CNT_W'(4)) begin
							if (csum != HDR_SUM_OK) begin
								emit        = 1'b1;
								r           = put_header(r, hdr_acc);
								r.event_res = EV_CSUM;
								ph_n        = PH_HUNT;
							end else if (len_acc != '0) begin
								ph_n = PH_PAYLOAD;
							end else if (hdr_acc[6]) begin
								ph_n = PH_CRC;
							end else begin
								finish = 1'b1;
							end
						end
					end
					PH_PAYLOAD: begin
						if (cnt_b == CNT_W'(4))
							pfx_n[7:0] = d;
						else if (cnt_b == CNT_W'(5))
							pfx_n[15:8] = d;
						emit         = 1'b1;
						r.data_valid = 1'b1;
						r.data_byte  = d;
						if (cnt_inc >= CNT_W'(len_b) + CNT_W'(4)) begin
							if (hdr_b[6])
								ph_n = PH_CRC;
							else
								finish = 1'b1;
						end
					end
					default: begin
						if (cnt_inc >= CNT_W'(len_b) + CNT_W'(6))
							finish = 1'b1;
					end
				endcase
				if (finish) begin
					emit           = 1'b1;
					r              = put_header(r, hdr_n);
					r.event_res    = EV_DONE;
					r.link_message = link_code(pfx_n, hdr_n);
					ph_n           = PH_HUNT;
					esc_n          = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			esc_q       <= 1'b0;
			cnt_q       <= '0;
			hdr_q       <= '0;
			pfx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= ph_n;
				esc_q   <= esc_n;
				cnt_q   <= cnt_n;
				hdr_q   <= hdr_n;
				pfx_q   <= pfx_n;
			end
			if (fire && emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit)
			res_q <= r;
	end

`ifndef SYNTH
	a_data_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.data_valid |->
			res_q.event_res == EV_NONE || res_q.event_res == EV_DONE)
		else $error("payload byte carries an error event");

	a_link_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.link_message != 3'd0 |->
			res_q.event_res == EV_DONE && res_q.packet_type == PKT_LINK)
		else $error("link message outside a completed link-control frame");

	a_slip_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && r.event_res == EV_SLIP |=> phase_q == PH_HUNT && !esc_q)
		else $error("slip error did not return to hunting");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("decoded count past frame end");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the three-wire SLIP deframer. Raw line bytes are driven
// through the uart channel, either as whole frames (with escapes, repeated
// delimiters, optional CRC bytes and link-control prefixes) or as broken
// frames and line noise. A bit-level model of the frame state machine runs
// on every accepted byte and queues the expected results. Each accepted
// result is checked field by field against that queue. The sender idles in
// random bursts, the receiver stalls on a random pattern, and one long
// receiver hold-off makes the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
	import h3w_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_ITEMS   = 1060;
	localparam int REPORT_LINES   = 200;

	typedef enum logic [2:0] {HUNTING, SKIPPING, IN_HEADER, IN_PAYLOAD, IN_CRC} rx_phase_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	h3w_in_if  uart_ch ();
	h3w_out_if res_ch ();

	hci_three_wire_slip_deframer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.uart    (uart_ch),
		.deframed(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// frame model state
	rx_phase_t   frame_phase = HUNTING;
	logic        esc_seen    = 1'b0;
	logic [12:0] byte_count  = '0;
	logic [31:0] frame_hdr   = '0;
	logic [15:0] link_bytes  = '0;
	res_t        frame_res_q[$];

	int   mismatch_count = 0;
	int   items_sent     = 0;
	int   quiet_cycles   = 0;
	int   burst_left     = 0;
	int   tx_gap_max     = 6;
	bit   rx_steady      = 1'b0;
	bit   hold_req       = 1'b0;
	int   hold_left      = 0;
	int   stall_pos      = 0;
	logic [31:0] stall_word = '0;

	function automatic logic [11:0] frame_len();
		return {frame_hdr[23:16], frame_hdr[15:12]};
	endfunction

	function automatic res_t with_header(input res_t r);
		res_t o;
		o                = r;
		o.packet_type    = frame_hdr[11:8];
		o.seq_number     = frame_hdr[2:0];
		o.ack_number     = frame_hdr[5:3];
		o.reliable_flag  = frame_hdr[7];
		o.crc_present    = frame_hdr[6];
		o.payload_length = frame_len();
		return o;
	endfunction

	function automatic logic [2:0] link_message_of();
		logic [2:0] code;
		code = 3'd0;
		if (frame_hdr[11:8] == PKT_LINK && frame_len() >= 12'd2) begin
			for (int i = 1; i <= LINK_NUM; i++) begin
				if (link_bytes[7:0] == 8'(i) && link_bytes[15:8] == LINK_SECOND[i - 1])
					code = 3'(i);
			end
		end
		return code;
	endfunction

	function automatic void close_frame(input res_t r);
		res_t o;
		o              = with_header(r);
		o.event_res    = EV_DONE;
		o.link_message = link_message_of();
		frame_phase    = HUNTING;
		esc_seen       = 1'b0;
		frame_res_q.push_back(o);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		res_t       r;
		logic [8:0] d;
		logic [7:0] sum;
		int         idx;
		r = '0;
		if (frame_phase == SKIPPING) begin
			if (b == SLIP_DELIM)
				return;
			esc_seen    = 1'b0;
			byte_count  = '0;
			frame_hdr   = '0;
			link_bytes  = '0;
			frame_phase = IN_HEADER;
		end else if (frame_phase == HUNTING) begin
			frame_phase = (b == SLIP_DELIM) ? SKIPPING : HUNTING;
			return;
		end

		if (!esc_seen && b == ESC_CODE) begin
			esc_seen = 1'b1;
			return;
		end
		if (b == SLIP_DELIM) begin
			d = 9'h100;
		end else if (esc_seen) begin
			esc_seen = 1'b0;
			if (b == ESC_FOR_DELIM)
				d = {1'b0, SLIP_DELIM};
			else if (b == ESC_FOR_ESC)
				d = {1'b0, ESC_CODE};
			else
				d = 9'h100;
		end else begin
			d = {1'b0, b};
		end
		if (d[8]) begin
			frame_phase = HUNTING;
			esc_seen    = 1'b0;
			r.event_res = EV_SLIP;
			frame_res_q.push_back(r);
			return;
		end

		case (frame_phase)
			IN_HEADER: begin
				frame_hdr[8 * byte_count[1:0] +: 8] = d[7:0];
				byte_count = byte_count + 13'd1;
				if (byte_count < 13'd4)
					return;
				sum = frame_hdr[7:0] + frame_hdr[15:8] + frame_hdr[23:16] + frame_hdr[31:24];
				if (sum != HDR_SUM_OK) begin
					r           = with_header(r);
					r.event_res = EV_CSUM;
					frame_phase = HUNTING;
					frame_res_q.push_back(r);
				end else if (frame_len() != 12'd0) begin
					frame_phase = IN_PAYLOAD;
				end else if (frame_hdr[6]) begin
					frame_phase = IN_CRC;
				end else begin
					close_frame(r);
				end
			end
			IN_PAYLOAD: begin
				idx = int'(byte_count) - 4;
				if (idx == 0)
					link_bytes[7:0] = d[7:0];
				else if (idx == 1)
					link_bytes[15:8] = d[7:0];
				byte_count   = byte_count + 13'd1;
				r.data_valid = 1'b1;
				r.data_byte  = d[7:0];
				if (int'(byte_count) < 4 + int'(frame_len())) begin
					frame_res_q.push_back(r);
				end else if (frame_hdr[6]) begin
					frame_phase = IN_CRC;
					frame_res_q.push_back(r);
				end else begin
					close_frame(r);
				end
			end
			default: begin
				byte_count = byte_count + 13'd1;
				if (int'(byte_count) >= 6 + int'(frame_len()))
					close_frame(r);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [11:0] got,
			input logic [11:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES)
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string name, input logic [11:0] got,
			input logic [11:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	task automatic check_result();
		res_t want;
		if (frame_res_q.size() == 0) begin
			report_mismatch("result with nothing expected", '0, '0);
			return;
		end
		want = frame_res_q.pop_front();
		compare_field("data_valid", 12'(res_ch.data_valid), 12'(want.data_valid));
		compare_field("data_byte", 12'(res_ch.data_byte), 12'(want.data_byte));
		compare_field("event_res", 12'(res_ch.event_res), 12'(want.event_res));
		compare_field("packet_type", 12'(res_ch.packet_type), 12'(want.packet_type));
		compare_field("seq_number", 12'(res_ch.seq_number), 12'(want.seq_number));
		compare_field("ack_number", 12'(res_ch.ack_number), 12'(want.ack_number));
		compare_field("reliable_flag", 12'(res_ch.reliable_flag),
			12'(want.reliable_flag));
		compare_field("crc_present", 12'(res_ch.crc_present), 12'(want.crc_present));
		compare_field("payload_length", res_ch.payload_length, want.payload_length);
		compare_field("link_message", 12'(res_ch.link_message), 12'(want.link_message));
	endtask

	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			check_result();
		if (uart_ch.valid === 1'b1 && uart_ch.ready === 1'b1)
			deframe_byte(uart_ch.in_byte);
	end

	always @(posedge clk) begin
		if (!arst_n || (uart_ch.valid === 1'b1 && uart_ch.ready === 1'b1)
				|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("hci_three_wire_slip_deframer test failed");
			$finish;
		end
	end

	// receiver: long hold-off on request, else a random stall pattern or steady ready
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				if (stall_pos == 0) begin
					if (rx_steady)
						stall_word = '0;
					else if ($urandom_range(0, 1))
						stall_word = $urandom() & $urandom();
					else
						stall_word = $urandom() | $urandom();
				end
				res_ch.ready <= ~stall_word[stall_pos];
				stall_pos = (stall_pos + 1) % 32;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				uart_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		uart_ch.valid   <= 1'b1;
		uart_ch.in_byte <= b;
		@(posedge clk);
		while (uart_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_decoded(input logic [7:0] d);
		if (d == SLIP_DELIM) begin
			send_byte(ESC_CODE);
			send_byte(ESC_FOR_DELIM);
		end else if (d == ESC_CODE) begin
			send_byte(ESC_CODE);
			send_byte(ESC_FOR_ESC);
		end else begin
			send_byte(d);
		end
	endtask

	task automatic send_break();
		logic [7:0] b;
		if ($urandom_range(0, 1)) begin
			send_byte(SLIP_DELIM);
		end else begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == ESC_FOR_DELIM || b == ESC_FOR_ESC);
			send_byte(ESC_CODE);
			send_byte(b);
		end
	endtask

	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 15))
			0: return SLIP_DELIM;
			1: return ESC_CODE;
			2: return ESC_FOR_DELIM;
			3: return ESC_FOR_ESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] rand_prefix();
		int k;
		int p;
		k = $urandom_range(1, LINK_NUM);
		p = $urandom_range(0, 9);
		if (p < 6)
			return {LINK_SECOND[k - 1], 8'(k)};
		else if (p < 8)
			return {8'($urandom_range(0, 255)), 8'(k)};
		else
			return 16'($urandom());
	endfunction

	function automatic logic [3:0] rand_type();
		return ($urandom_range(0, 2) == 0) ? PKT_LINK : 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [11:0] rand_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 12'($urandom_range(0, 4));
		else if (p < 90)
			return 12'($urandom_range(5, 20));
		else
			return 12'($urandom_range(21, 64));
	endfunction

	// cut_at: index of the decoded byte replaced by a line break, -1 for none
	task automatic send_frame(input logic [3:0] ptype, input logic [7:0] b0,
			input logic [11:0] len, input logic [15:0] prefix, input bit bad_sum,
			input int cut_at);
		logic [7:0] dec[$];
		logic [7:0] sum;
		dec.push_back(b0);
		dec.push_back({len[3:0], ptype});
		dec.push_back(len[11:4]);
		sum = b0 + {len[3:0], ptype} + len[11:4];
		sum = HDR_SUM_OK - sum;
		if (bad_sum)
			sum = sum + 8'($urandom_range(1, 255));
		dec.push_back(sum);
		if (!bad_sum) begin
			for (int i = 0; i < int'(len); i++)
				dec.push_back(i == 0 ? prefix[7:0] : i == 1 ? prefix[15:8] : rand_data());
			if (b0[6])
				repeat (2) dec.push_back(rand_data());
		end
		repeat ($urandom_range(1, 3)) send_byte(SLIP_DELIM);
		foreach (dec[i]) begin
			if (i == cut_at) begin
				send_break();
				return;
			end
			send_decoded(dec[i]);
		end
	endtask

	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(PKT_LINK, 8'hFF, 12'd2, {8'h7E, 8'h01}, 1'b0, -1);
		send_frame(4'h0, 8'h00, 12'd0, 16'h0000, 1'b0, -1);
		send_frame(4'h2, 8'h40, 12'd0, 16'h0000, 1'b0, -1);
		send_frame(PKT_LINK, 8'h3A, 12'd1, {8'h7E, 8'h01}, 1'b0, -1);
		send_frame(PKT_LINK, 8'hFF, 12'hFFF, 16'hFFFF, 1'b1, -1);
		send_frame(4'h1, 8'h12, 12'd3, rand_prefix(), 1'b0, 6);
		send_frame(PKT_LINK, 8'h00, 12'hFFF, {8'h78, 8'h07}, 1'b0, 7);
	endtask

	task automatic test_hold_off();
		tx_gap_max = 0;
		rx_steady  = 1'b0;
		hold_req   = 1'b1;
		repeat (12)
			send_frame(rand_type(), 8'($urandom_range(0, 255)), 12'($urandom_range(2, 8)),
				rand_prefix(), 1'b0, -1);
		send_frame(PKT_LINK, 8'h47, 12'd300, rand_prefix(), 1'b0, -1);
		tx_gap_max = 6;
	endtask

	task automatic test_random_traffic();
		int          start_count;
		int          pick;
		logic [11:0] len;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				rx_steady  = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			len  = rand_length();
			if (pick < 65)
				send_frame(rand_type(), 8'($urandom_range(0, 255)), len, rand_prefix(),
					1'b0, -1);
			else if (pick < 75)
				send_frame(rand_type(), 8'($urandom_range(0, 255)), len, rand_prefix(),
					1'b1, -1);
			else if (pick < 90)
				send_frame(rand_type(), 8'($urandom_range(0, 255)), len, rand_prefix(),
					1'b0, $urandom_range(0, 5 + int'(len)));
			else
				repeat ($urandom_range(1, 6)) send_byte(rand_data());
		end
	endtask

	initial begin
		uart_ch.valid   <= 1'b0;
		uart_ch.in_byte <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_hold_off();
		test_random_traffic();
		uart_ch.valid <= 1'b0;
		@(posedge clk);
		while (frame_res_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("hci_three_wire_slip_deframer test passed");
		else
			$display("hci_three_wire_slip_deframer test failed");
		$finish;
	end

endmodule
